// ===== rtl/core/iat_pkg.sv =====
// ----------------------------------------------------------------------------
// iat_pkg - shared types, constants and helpers for ip_address_to_text
// Controller/datapath command and status words, ASCII codes and the
// digit helpers used when the address text is produced.
// ----------------------------------------------------------------------------
package iat_pkg;

  // ASCII codes used in the address text
  localparam logic [6:0] CHR_ZERO  = 7'h30;
  localparam logic [6:0] CHR_LOW_A = 7'h61;
  localparam logic [6:0] CHR_COLON = 7'h3a;
  localparam logic [6:0] CHR_DOT   = 7'h2e;
  localparam logic [6:0] CHR_ONE   = 7'h31;
  localparam logic [6:0] CHR_TWO   = 7'h32;

  // Address layout
  localparam int unsigned NUM_GROUPS  = 8;
  localparam int unsigned GROUP_W     = 16;
  localparam int unsigned ADDR_HALF_W = 64;

  // Family code on the op field
  localparam logic FAM_IPV4 = 1'b0;
  localparam logic FAM_IPV6 = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture a new address
    logic scan;  // find the zero run and set up the first character
    logic emit;  // produce one character into the output register
  } iat_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;  // the character being produced ends the text
  } iat_status_t;

  // Index of the leading hex digit of a group (digits - 1)
  function automatic logic [1:0] hex_top_digit(logic [15:0] g);
    logic [1:0] k;
    priority if (g >= 16'h1000) k = 2'd3;
    else if (g >= 16'h0100)     k = 2'd2;
    else if (g >= 16'h0010)     k = 2'd1;
    else                        k = 2'd0;
    return k;
  endfunction

  // Lower-case hex character of one nibble
  function automatic logic [6:0] hex_char(logic [3:0] n);
    logic [6:0] c;
    if (n < 4'd10) c = CHR_ZERO + {3'b000, n};
    else           c = CHR_LOW_A + {3'b000, n} - 7'd10;
    return c;
  endfunction

  // Index of the leading decimal digit of an octet
  function automatic logic [1:0] dec_top_digit(logic [7:0] v);
    logic [1:0] d;
    priority if (v >= 8'd100) d = 2'd2;
    else if (v >= 8'd10)      d = 2'd1;
    else                      d = 2'd0;
    return d;
  endfunction

  // Decimal digit d (2 hundreds, 1 tens, 0 ones) of an octet as ASCII.
  // v / 10 is taken as (v * 205) >> 11, exact for all octets.
  function automatic logic [6:0] dec_char(logic [7:0] v, logic [1:0] d);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  q10;
    logic [4:0]  tens_w;
    logic [3:0]  tens;
    logic [7:0]  ones_w;
    logic [6:0]  c;
    prod = {8'b0, v} * 16'd205;
    q    = prod[15:11];
    q10  = {q, 3'b000} + {2'b00, q, 1'b0};
    priority if (q >= 5'd20) tens_w = q - 5'd20;
    else if (q >= 5'd10)     tens_w = q - 5'd10;
    else                     tens_w = q;
    tens   = tens_w[3:0];
    ones_w = v - q10;
    unique case (d)
      2'd2:    c = (v >= 8'd200) ? CHR_TWO : CHR_ONE;
      2'd1:    c = CHR_ZERO + {3'b000, tens};
      default: c = CHR_ZERO + {3'b000, ones_w[3:0]};
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/ip_address_to_text.sv =====
// ----------------------------------------------------------------------------
// ip_address_to_text - IPv4 / IPv6 address to ASCII text streamer
// Turns one address into its text form, one character per output word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one address: op_i picks
//   IPv4 (address in addr_lo_i[31:0]) or IPv6 (addr_hi_i, addr_lo_i).
//   Output channel (out_valid_o / out_ready_i) carries one ASCII character
//   per word in char_out_o; last_char_o marks the final character.
//   The first character becomes valid once the address has been captured,
//   the zero-run search and setup step has run and the first character has
//   been emitted into the output register. The text length n is 2 to 39
//   for IPv6 and 7 to 15 for IPv4; the character generator produces one
//   character per cycle while the receiver takes every word.
//   in_ready_o rises as soon as the last character sits in the output
//   register, so the next address is taken while that word waits.
//   A stalled receiver holds the output word and freezes the generator.
//   Reset empties the output register and returns to waiting for input.
// ----------------------------------------------------------------------------
module ip_address_to_text (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [63:0] addr_hi_i,
  input  logic [63:0] addr_lo_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  char_out_o,
  output logic        last_char_o
);

  iat_pkg::iat_cmd_t    cmd;
  iat_pkg::iat_status_t status;

  // sequencing
  iat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // address store and character generator
  iat_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .op_i        (op_i),
    .addr_hi_i   (addr_hi_i),
    .addr_lo_i   (addr_lo_i),
    .char_out_o  (char_out_o),
    .last_char_o (last_char_o)
  );

endmodule

// ===== rtl/core/iat_datapath.sv =====
// ----------------------------------------------------------------------------
// iat_datapath - address store, zero-run search and character generator
// Holds the captured address, finds the longest zero-group run and steps
// through the text one character per emit command.
// ----------------------------------------------------------------------------
module iat_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iat_pkg::iat_cmd_t    cmd_i,
  output iat_pkg::iat_status_t status_o,
  input  logic                 op_i,
  input  logic [63:0]          addr_hi_i,
  input  logic [63:0]          addr_lo_i,
  output logic [6:0]           char_out_o,
  output logic                 last_char_o
);

  // what the generator produces next
  typedef enum logic [2:0] {
    GK_SEP,   // ':' before a group or at the start of the zero run
    GK_DIG,   // hex digit of a group
    GK_V4D,   // decimal digit of an IPv4 octet
    GK_DOT,   // '.' between octets
    GK_TAIL   // ':' closing a zero run that reaches the last group
  } gen_kind_e;

  // captured address
  logic        op_q;
  logic [63:0] addr_hi_q, addr_lo_q;

  // generator position and zero-run result
  gen_kind_e   kind_q, kind_d;
  logic [2:0]  gi_q, gi_d;
  logic [1:0]  k_q, k_d;
  logic [1:0]  o_q, o_d;
  logic [1:0]  d_q, d_d;
  logic        run_ok_q, run_ok_d;
  logic [2:0]  base_q, base_d;
  logic [3:0]  end_q, end_d;
  logic        v4tail_q, v4tail_d;

  // output word
  logic [6:0]  char_q, char_d;
  logic        last_q, last_d;

  logic [15:0] grp [iat_pkg::NUM_GROUPS];
  logic [15:0] grp_sel;
  logic [3:0]  nib;
  logic [7:0]  oct_cur, oct_nxt, oct_top;
  logic [1:0]  o_dec;

  // split the address into 16-bit groups, group 0 first
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      grp[i]     = addr_hi_q[63 - 16*i -: 16];
      grp[i + 4] = addr_lo_q[63 - 16*i -: 16];
    end
  end

  assign grp_sel = grp[gi_q];
  assign o_dec   = o_q - 2'd1;
  assign oct_cur = addr_lo_q[{o_q, 3'b000} +: 8];
  assign oct_nxt = addr_lo_q[{o_dec, 3'b000} +: 8];
  assign oct_top = addr_lo_q[31:24];

  always_comb begin
    unique case (k_q)
      2'd3:    nib = grp_sel[15:12];
      2'd2:    nib = grp_sel[11:8];
      2'd1:    nib = grp_sel[7:4];
      default: nib = grp_sel[3:0];
    endcase
  end

  // zero-run search, first longest run wins
  logic [3:0] cb, cl, bb, bl;
  logic       cv;
  always_comb begin
    cb = '0;
    cl = '0;
    bb = '0;
    bl = '0;
    cv = 1'b0;
    for (int i = 0; i < iat_pkg::NUM_GROUPS; i++) begin
      if (grp[i] == 16'h0000) begin
        if (!cv) begin
          cv = 1'b1;
          cb = 4'(i);
          cl = 4'd1;
        end else begin
          cl = cl + 4'd1;
        end
      end else if (cv) begin
        if (cl > bl) begin
          bb = cb;
          bl = cl;
        end
        cv = 1'b0;
      end
    end
    if (cv && (cl > bl)) begin
      bb = cb;
      bl = cl;
    end
  end

  // generator step and setup
  always_comb begin
    kind_d   = kind_q;
    gi_d     = gi_q;
    k_d      = k_q;
    o_d      = o_q;
    d_d      = d_q;
    run_ok_d = run_ok_q;
    base_d   = base_q;
    end_d    = end_q;
    v4tail_d = v4tail_q;
    char_d   = char_q;
    last_d   = 1'b0;

    if (cmd_i.scan) begin
      run_ok_d = (bl >= 4'd2);
      base_d   = bb[2:0];
      end_d    = bb + bl;
      v4tail_d = (bl >= 4'd2) && (bb == 4'd0) &&
                 ((bl == 4'd6) || ((bl == 4'd5) && (grp[5] == 16'hffff)));
      gi_d     = 3'd0;
      o_d      = 2'd3;
      d_d      = iat_pkg::dec_top_digit(oct_top);
      k_d      = iat_pkg::hex_top_digit(grp[0]);
      if (op_q == iat_pkg::FAM_IPV4) begin
        kind_d = GK_V4D;
      end else if ((bl >= 4'd2) && (bb == 4'd0)) begin
        kind_d = GK_SEP;
      end else begin
        kind_d = GK_DIG;
      end
    end else if (cmd_i.emit) begin
      unique case (kind_q)
        GK_SEP: begin
          char_d = iat_pkg::CHR_COLON;
          if (run_ok_q && (gi_q == base_q)) begin
            if (end_q == 4'(iat_pkg::NUM_GROUPS)) begin
              kind_d = GK_TAIL;
            end else begin
              kind_d = GK_SEP;
              gi_d   = end_q[2:0];
            end
          end else if (v4tail_q && (gi_q == 3'd6)) begin
            kind_d = GK_V4D;
            o_d    = 2'd3;
            d_d    = iat_pkg::dec_top_digit(oct_top);
          end else begin
            kind_d = GK_DIG;
            k_d    = iat_pkg::hex_top_digit(grp_sel);
          end
        end
        GK_DIG: begin
          char_d = iat_pkg::hex_char(nib);
          if (k_q != 2'd0) begin
            k_d = k_q - 2'd1;
          end else if (gi_q == 3'd7) begin
            last_d = 1'b1;
          end else begin
            kind_d = GK_SEP;
            gi_d   = gi_q + 3'd1;
          end
        end
        GK_V4D: begin
          char_d = iat_pkg::dec_char(oct_cur, d_q);
          if (d_q != 2'd0) begin
            d_d = d_q - 2'd1;
          end else if (o_q == 2'd0) begin
            last_d = 1'b1;
          end else begin
            kind_d = GK_DOT;
          end
        end
        GK_DOT: begin
          char_d = iat_pkg::CHR_DOT;
          kind_d = GK_V4D;
          o_d    = o_dec;
          d_d    = iat_pkg::dec_top_digit(oct_nxt);
        end
        GK_TAIL: begin
          char_d = iat_pkg::CHR_COLON;
          last_d = 1'b1;
        end
        default: begin
          char_d = iat_pkg::CHR_COLON;
          last_d = 1'b1;
        end
      endcase
    end
  end

  // generator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= GK_TAIL;
      gi_q     <= '0;
      k_q      <= '0;
      o_q      <= '0;
      d_q      <= '0;
      run_ok_q <= 1'b0;
      base_q   <= '0;
      end_q    <= '0;
      v4tail_q <= 1'b0;
    end else begin
      kind_q   <= kind_d;
      gi_q     <= gi_d;
      k_q      <= k_d;
      o_q      <= o_d;
      d_q      <= d_d;
      run_ok_q <= run_ok_d;
      base_q   <= base_d;
      end_q    <= end_d;
      v4tail_q <= v4tail_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_i;
      addr_hi_q <= addr_hi_i;
      addr_lo_q <= addr_lo_i;
    end
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  assign status_o.last = last_d;
  assign char_out_o    = char_q;
  assign last_char_o   = last_q;

endmodule

// ===== rtl/core/iat_ctrl.sv =====
// ----------------------------------------------------------------------------
// iat_ctrl - sequencing state machine for ip_address_to_text
// Accepts an address, runs the setup cycle, then issues one emit per
// free slot of the output register until the last character.
// ----------------------------------------------------------------------------
module iat_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output iat_pkg::iat_cmd_t    cmd_o,
  input  iat_pkg::iat_status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  // output register can take a word this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  // commands
  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o.load = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.scan = (state_q == ST_SCAN);
  assign cmd_o.emit = (state_q == ST_EMIT) && slot_free;

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (cmd_o.emit && status_i.last) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/ip_address_to_text_checker.sv =====
// ----------------------------------------------------------------------------
// ip_address_to_text_sva - port-level checks for ip_address_to_text
// Watches the two channels and flags words or handshakes that break the
// block's behaviour; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ip_address_to_text_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] char_out_o,
  input logic       last_char_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(char_out_o) && $stable(last_char_o))
    else $error("output word changed while stalled");

  // one address at a time: input closes after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an address is in work");

  // input reopens only with the final character waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o && last_char_o)
    else $error("input reopened before the final character");

  // only digits, lower-case hex, colon and dot appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((char_out_o >= 7'h30) && (char_out_o <= 7'h3a)) ||
      ((char_out_o >= 7'h61) && (char_out_o <= 7'h66)) ||
      (char_out_o == 7'h2e))
    else $error("character outside the address alphabet");

endmodule

bind ip_address_to_text ip_address_to_text_sva u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .char_out_o  (char_out_o),
  .last_char_o (last_char_o)
);

// ===== sim/ip_address_to_text_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_address_to_text_checker - text predictor and output comparator
// Watches both channels of ip_address_to_text. Every address taken on the
// input side is turned into the characters it should produce; every word
// taken on the output side is compared against the oldest of them.
// ----------------------------------------------------------------------------
module ip_address_to_text_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic [63:0] addr_hi_i,
  input  logic [63:0] addr_lo_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [6:0]  char_out_i,
  input  logic        last_char_i,
  output int          fail_count_o,
  output int          chars_pending_o
);

  typedef struct packed {
    logic [6:0] chr;
    logic       last;
  } text_word_t;

  text_word_t expected_text[$];
  logic [6:0] text_buf[$];
  int         fails;
  int         pending;

  assign fail_count_o    = fails;
  assign chars_pending_o = pending;

  // Dotted decimal, octets without leading zeros
  function automatic void append_dotted_quad(input logic [31:0] a);
    logic [7:0] v;
    for (int k = 3; k >= 0; k--) begin
      v = a[8*k +: 8];
      if (v >= 8'd200) text_buf.push_back(iat_pkg::CHR_TWO);
      else if (v >= 8'd100) text_buf.push_back(iat_pkg::CHR_ONE);
      if (v >= 8'd10)
        text_buf.push_back(iat_pkg::CHR_ZERO + 7'((v / 8'd10) % 8'd10));
      text_buf.push_back(iat_pkg::CHR_ZERO + 7'(v % 8'd10));
      if (k > 0) text_buf.push_back(iat_pkg::CHR_DOT);
    end
  endfunction

  // Full text of one address, queued as expected words
  function automatic void predict_text(input logic fam, input logic [63:0] hi,
                                       input logic [63:0] lo);
    logic [15:0] grp[iat_pkg::NUM_GROUPS];
    logic [3:0]  nib;
    int          run_base;
    int          run_len;
    int          best_base;
    int          best_len;
    int          digits;
    text_word_t  w;
    text_buf.delete();
    if (fam == iat_pkg::FAM_IPV4) begin
      append_dotted_quad(lo[31:0]);
    end else begin
      for (int i = 0; i < 4; i++) begin
        grp[i]     = hi[63-16*i -: 16];
        grp[i + 4] = lo[63-16*i -: 16];
      end
      // longest zero run, first one wins a tie
      run_base  = -1;
      run_len   = 0;
      best_base = -1;
      best_len  = 0;
      for (int i = 0; i < iat_pkg::NUM_GROUPS; i++) begin
        if (grp[i] == 16'h0000) begin
          if (run_base < 0) begin
            run_base = i;
            run_len  = 1;
          end else begin
            run_len++;
          end
        end else if (run_base >= 0) begin
          if (run_len > best_len) begin
            best_base = run_base;
            best_len  = run_len;
          end
          run_base = -1;
        end
      end
      if (run_base >= 0 && run_len > best_len) begin
        best_base = run_base;
        best_len  = run_len;
      end
      if (best_len < 2) best_base = -1;
      // groups, with the run shortened to a double colon
      for (int i = 0; i < iat_pkg::NUM_GROUPS; i++) begin
        if (best_base >= 0 && i >= best_base && i < best_base + best_len) begin
          if (i == best_base) text_buf.push_back(iat_pkg::CHR_COLON);
          continue;
        end
        if (i != 0) text_buf.push_back(iat_pkg::CHR_COLON);
        // mapped and compatible forms end in dotted decimal
        if (i == 6 && best_base == 0 &&
            (best_len == 6 || (best_len == 5 && grp[5] == 16'hffff))) begin
          append_dotted_quad(lo[31:0]);
          break;
        end
        if (grp[i] >= 16'h1000) digits = 4;
        else if (grp[i] >= 16'h0100) digits = 3;
        else if (grp[i] >= 16'h0010) digits = 2;
        else digits = 1;
        for (int k = digits - 1; k >= 0; k--) begin
          nib = grp[i][4*k +: 4];
          text_buf.push_back(nib < 4'd10 ? iat_pkg::CHR_ZERO + 7'(nib)
                                         : iat_pkg::CHR_LOW_A + 7'(nib) - 7'd10);
        end
      end
      if (best_base >= 0 && best_base + best_len == iat_pkg::NUM_GROUPS)
        text_buf.push_back(iat_pkg::CHR_COLON);
    end
    foreach (text_buf[j]) begin
      w.chr  = text_buf[j];
      w.last = (j == text_buf.size() - 1);
      expected_text.push_back(w);
    end
  endfunction

  // Compare output words first, then predict for a newly taken address
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    text_word_t w;
    if (!rst_ni) begin
      expected_text.delete();
      fails   = 0;
      pending = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_text.size() == 0) begin
          $error("unexpected word: char_out 'h%02h, last_char %b", char_out_i, last_char_i);
          fails++;
        end else begin
          w = expected_text.pop_front();
          if (char_out_i !== w.chr) begin
            $error("char_out: expected 'h%02h, actual 'h%02h", w.chr, char_out_i);
            fails++;
          end
          if (last_char_i !== w.last) begin
            $error("last_char: expected %b, actual %b", w.last, last_char_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_text(op_i, addr_hi_i, addr_lo_i);
      pending = expected_text.size();
    end
  end

endmodule

// ===== sim/tb_ip_address_to_text.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ip_address_to_text - testbench for the address text streamer
// Sends directed and random IPv4 / IPv6 addresses with random sender gaps
// and receiver stalls; the checker beside the block predicts every word.
// ----------------------------------------------------------------------------
module tb_ip_address_to_text;

  localparam int unsigned RANDOM_ITEMS = 288;
  localparam int unsigned TAIL_ITEMS   = 40;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 800_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        op_i;
  logic [63:0] addr_hi_i;
  logic [63:0] addr_lo_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [6:0]  char_out_o;
  logic        last_char_o;

  int          fail_count;
  int          chars_pending;
  bit          sender_idles;
  bit          receiver_stalls;
  int unsigned cycle_count;

  ip_address_to_text DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .addr_hi_i   (addr_hi_i),
    .addr_lo_i   (addr_lo_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_out_o  (char_out_o),
    .last_char_o (last_char_o)
  );

  ip_address_to_text_checker u_text_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .op_i            (op_i),
    .addr_hi_i       (addr_hi_i),
    .addr_lo_i       (addr_lo_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .char_out_i      (char_out_o),
    .last_char_i     (last_char_o),
    .fail_count_o    (fail_count),
    .chars_pending_o (chars_pending)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run guard
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: ready, with random stall bursts
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // One address word; entered and left at a falling edge, valid still high
  task automatic send_address(input logic fam, input logic [63:0] hi,
                              input logic [63:0] lo);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i       = fam;
    addr_hi_i  = hi;
    addr_lo_i  = lo;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] grp;
    logic [7:0]  oct;
    in_valid_i      = 1'b0;
    op_i            = iat_pkg::FAM_IPV4;
    addr_hi_i       = '0;
    addr_lo_i       = '0;
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    rst_ni          = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // IPv4 extremes, digit-count boundaries, ignored upper bits
    send_address(iat_pkg::FAM_IPV4, 64'h0, 64'h0);
    send_address(iat_pkg::FAM_IPV4, 64'h0, 64'h0000_0000_ffff_ffff);
    send_address(iat_pkg::FAM_IPV4, '1, 64'hffff_ffff_0102_0304);
    send_address(iat_pkg::FAM_IPV4, 64'h0, 64'h0000_0000_0a63_64c7);
    send_address(iat_pkg::FAM_IPV4, 64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_c809_6dfa);
    // IPv6: all zero, all ones, trailing and leading runs
    send_address(iat_pkg::FAM_IPV6, 64'h0, 64'h0);
    send_address(iat_pkg::FAM_IPV6, '1, '1);
    send_address(iat_pkg::FAM_IPV6, 64'h0001_0000_0000_0000, 64'h0);
    send_address(iat_pkg::FAM_IPV6, 64'h0, 64'h0000_0000_0000_0001);
    // single zero group stays as a digit
    send_address(iat_pkg::FAM_IPV6, 64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007);
    // equal runs: first wins; longer later run wins
    send_address(iat_pkg::FAM_IPV6, 64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004);
    send_address(iat_pkg::FAM_IPV6, 64'h0001_0000_0000_0002, 64'h0000_0000_0000_0003);
    send_address(iat_pkg::FAM_IPV6, 64'h0000_0000_0001_0002, 64'h0003_0004_0000_0000);
    // mapped and compatible forms, and near misses
    send_address(iat_pkg::FAM_IPV6, 64'h0, 64'h0000_ffff_0102_0304);
    send_address(iat_pkg::FAM_IPV6, 64'h0, 64'h0000_0000_c0a8_0001);
    send_address(iat_pkg::FAM_IPV6, 64'h0, 64'h0000_ffff_0000_0000);
    send_address(iat_pkg::FAM_IPV6, 64'h0, 64'h0000_1234_c0a8_0001);
    send_address(iat_pkg::FAM_IPV6, 64'h0, 64'h0000_0001_0000_0000);
    send_address(iat_pkg::FAM_IPV6, 64'h0001_0000_0000_0000, 64'h0000_0000_0000_0002);
    send_address(iat_pkg::FAM_IPV6, 64'h0000_0000_0000_0000, 64'hffff_ffff_0a00_0001);
    // every digit count, longest text, short trailing run
    send_address(iat_pkg::FAM_IPV6, 64'h0001_0010_0100_1000, 64'h000f_00ff_0fff_ffff);
    send_address(iat_pkg::FAM_IPV6, 64'h1234_5678_9abc_def0, 64'h1111_2222_3333_ffff);
    send_address(iat_pkg::FAM_IPV6, 64'h0001_0002_0003_0004, 64'h0005_0006_0000_0000);

    // Random addresses, biased towards zero runs and boundary values
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sender_idles    = (n < RANDOM_ITEMS - TAIL_ITEMS) && ((n / 50) % 3 != 2);
      receiver_stalls = sender_idles;
      // hold off until the block has drained completely
      if (n == RANDOM_ITEMS / 2) begin
        in_valid_i = 1'b0;
        while (chars_pending != 0) @(negedge clk_i);
      end
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 2))
              0:       oct = 8'($urandom_range(0, 9));
              1:       oct = 8'($urandom_range(10, 99));
              default: oct = 8'($urandom_range(100, 255));
            endcase
            lo[8*k +: 8] = oct;
          end
          send_address(iat_pkg::FAM_IPV4, hi, lo);
        end
        8: begin
          lo[63:32] = {16'h0000, ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000};
          send_address(iat_pkg::FAM_IPV6, 64'h0, lo);
        end
        9: send_address(iat_pkg::FAM_IPV6, hi, lo);
        default: begin
          for (int i = 0; i < iat_pkg::NUM_GROUPS; i++) begin
            case ($urandom_range(0, 5))
              0, 1:    grp = 16'h0000;
              2:       grp = 16'hffff;
              default: grp = 16'($urandom) >> (4 * $urandom_range(0, 3));
            endcase
            if (i < 4) hi[63-16*i -: 16] = grp;
            else lo[127-16*i -: 16] = grp;
          end
          send_address(iat_pkg::FAM_IPV6, hi, lo);
        end
      endcase
    end
    in_valid_i = 1'b0;

    // Drain, then allow any stray word to show
    while (chars_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
